@@ rtl/rgbk_pkg.sv @@
package rgbk_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int PIX_W      = 8;
  localparam int RGB_W      = 3 * PIX_W;
  localparam int KMODE_W    = 2;
  localparam int CFG_DIM_W  = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  localparam int DIM_RESET = 1024;
  localparam int DIM_MIN   = 3;

  // Box blur divides by 9 through a scaled reciprocal; exact for sums up to 2299.
  localparam int RECIP9    = 7282;
  localparam int RECIP9_SH = 16;
  localparam int BOX_RND   = 4;
  localparam int GAUSS_RND = 8;
  localparam int GAUSS_SH  = 4;
  localparam int PIX_MAX   = 255;

  typedef enum logic [KMODE_W-1:0] {
    KM_EDGE,
    KM_SHARPEN,
    KM_BOX,
    KM_GAUSS
  } kmode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_MODE,
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT
  } cfg_reg_t;

  typedef logic [RGB_W-1:0] pix_t;
  typedef logic [8:0][PIX_W-1:0] tap9_t;

  // One channel of the 3x3 kernel. Taps are row-major, top-left first.
  function automatic logic [PIX_W-1:0] filt_chan(kmode_t mode, tap9_t p);
    logic [11:0]        all_s;
    logic [9:0]         cross_s;
    logic [9:0]         corner_s;
    logic [PIX_W-1:0]   ctr;
    logic signed [13:0] sum;
    logic [24:0]        prod;
    logic [PIX_W-1:0]   res;
    ctr      = p[4];
    cross_s  = 10'(p[1]) + 10'(p[3]) + 10'(p[5]) + 10'(p[7]);
    corner_s = 10'(p[0]) + 10'(p[2]) + 10'(p[6]) + 10'(p[8]);
    all_s    = 12'(cross_s) + 12'(corner_s) + 12'(ctr);
    prod     = '0;
    sum      = '0;
    case (mode)
      KM_EDGE: begin
        sum = signed'(14'({ctr, 3'b000}) - 14'(all_s - 12'(ctr)));
      end
      KM_SHARPEN: begin
        sum = signed'(14'({ctr, 2'b00}) + 14'(ctr) - 14'(cross_s));
      end
      KM_BOX: begin
        prod = 25'(all_s + 12'(BOX_RND)) * 25'(RECIP9);
        sum  = signed'(14'(prod >> RECIP9_SH));
      end
      KM_GAUSS: begin
        sum = signed'((14'(corner_s) + 14'({cross_s, 1'b0}) + 14'({ctr, 2'b00})
                       + 14'(GAUSS_RND)) >> GAUSS_SH);
      end
      default: begin
        sum = '0;
      end
    endcase
    if (sum < 0) begin
      res = '0;
    end else if (sum > PIX_MAX) begin
      res = '1;
    end else begin
      res = sum[PIX_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/rgb_3x3_kernel_convolution.sv @@
// 3x3 RGB convolution over a raster pixel stream. One transaction is taken per clock
// when the output is not stalled (valid/ready on both sides); each result passes
// through stage A (registered reads of both line buffers) and the output register; it
// is the pixel one row and one column behind the input. Kernel: edge, sharpen, box
// blur (/9) or Gaussian (/16), selected by kernel_mode; blur results round half up and
// every result is clamped to 0..255. Border pixels pass through unchanged. After the
// last pixel of a frame, send image_width+1 transactions with in_is_pad set to flush
// the tail; out_frame_last marks the final pixel. Width and height are clamped to
// 3..MAX_WIDTH / 3..MAX_HEIGHT. Write the configuration only while the block is idle.
// Line buffers need no clearing after reset: unwritten entries only reach border taps.
module rgb_3x3_kernel_convolution #(
  parameter int MAX_WIDTH  = rgbk_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rgbk_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rgbk_pkg::PIX_W-1:0]      in_red,
  input  logic [rgbk_pkg::PIX_W-1:0]      in_green,
  input  logic [rgbk_pkg::PIX_W-1:0]      in_blue,
  input  logic                            in_is_pad,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rgbk_pkg::PIX_W-1:0]      out_red,
  output logic [rgbk_pkg::PIX_W-1:0]      out_green,
  output logic [rgbk_pkg::PIX_W-1:0]      out_blue,
  output logic                            out_frame_last,
  input  logic                            cfg_wr_en,
  input  logic [rgbk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgbk_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rgbk_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);       // column / line-buffer address
  localparam int WW = $clog2(MAX_WIDTH + 1);   // effective width
  localparam int HW = $clog2(MAX_HEIGHT + 1);  // effective height
  localparam int RW = $clog2(MAX_HEIGHT + 3);  // row counter, runs to height+1

  // Configuration registers
  kmode_t               kmode_r;
  logic [CFG_DIM_W-1:0] img_w_r;
  logic [CFG_DIM_W-1:0] img_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmode_r <= KM_EDGE;
      img_w_r <= CFG_DIM_W'(DIM_RESET);
      img_h_r <= CFG_DIM_W'(DIM_RESET);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_KERNEL_MODE:  kmode_r <= kmode_t'(cfg_wdata[KMODE_W-1:0]);
        REG_IMAGE_WIDTH:  img_w_r <= cfg_wdata[CFG_DIM_W-1:0];
        REG_IMAGE_HEIGHT: img_h_r <= cfg_wdata[CFG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame size into the supported range
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  always_comb begin
    if (32'(img_w_r) < DIM_MIN) begin
      eff_w = WW'(DIM_MIN);
    end else if (32'(img_w_r) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(img_w_r);
    end
    if (32'(img_h_r) < DIM_MIN) begin
      eff_h = HW'(DIM_MIN);
    end else if (32'(img_h_r) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(img_h_r);
    end
  end

  // Handshake: stage A holds the item whose line-buffer reads are in flight,
  // the output register holds a finished result.
  logic out_valid_r;
  logic a_valid_r;
  logic a_res_r;
  logic out_adv;
  logic a_fire;
  logic in_fire;

  assign out_adv  = !out_valid_r || out_ready;
  assign a_fire   = a_valid_r && (!a_res_r || out_adv);
  assign in_ready = !a_valid_r || a_fire;
  assign in_fire  = in_valid && in_ready;

  // Frame position of the incoming transaction
  logic [AW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [AW-1:0] pos_c;
  logic [RW-1:0] pos_r;
  logic [AW-1:0] x_c;
  logic [RW-1:0] y_c;
  logic          restart;
  logic          res_c;
  logic          border_c;
  logic          last_c;

  always_comb begin
    // Restart the count when the position has fallen outside the frame
    restart = (32'(col_r) >= 32'(eff_w)) || (32'(row_r) > 32'(eff_h) + 1);
    pos_c   = restart ? '0 : col_r;
    pos_r   = restart ? '0 : row_r;
    y_c     = '0;
    x_c     = '0;
    res_c   = 1'b0;
    if (pos_c != '0) begin
      if (pos_r != '0) begin
        y_c   = pos_r - RW'(1);
        x_c   = pos_c - AW'(1);
        res_c = 32'(y_c) < 32'(eff_h);
      end
    end else if (32'(pos_r) >= 2) begin
      // First column of a row: the output is the last pixel of the row before
      y_c   = pos_r - RW'(2);
      x_c   = AW'(eff_w - WW'(1));
      res_c = 32'(y_c) < 32'(eff_h);
    end
    border_c = (y_c == '0) || (32'(y_c) == 32'(eff_h) - 1)
            || (x_c == '0) || (32'(x_c) == 32'(eff_w) - 1);
    last_c   = res_c && (32'(y_c) == 32'(eff_h) - 1) && (32'(x_c) == 32'(eff_w) - 1);
    if (last_c) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (32'(pos_c) + 1 >= 32'(eff_w)) begin
      col_nxt = '0;
      row_nxt = pos_r + RW'(1);
    end else begin
      col_nxt = pos_c + AW'(1);
      row_nxt = pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Stage A: capture the transaction and read both line buffers at its column
  pix_t          pix_c;
  pix_t          a_pix_r;
  logic [AW-1:0] a_addr_r;
  logic          a_border_r;
  logic          a_last_r;

  assign pix_c = in_is_pad ? '0 : {in_red, in_green, in_blue};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_pix_r    <= pix_c;
      a_addr_r   <= pos_c;
      a_res_r    <= res_c;
      a_border_r <= border_c;
      a_last_r   <= last_c;
    end
  end

  // Line buffers: line A holds the previous row, line B the row before that
  pix_t mem_a [MAX_WIDTH];
  pix_t mem_b [MAX_WIDTH];
  pix_t rd_a_r, rd_b_r;
  pix_t fwd_a_r, fwd_b_r;
  logic fwd_r;
  pix_t line_a_q, line_b_q;

  // A read that hits the column being written this cycle takes the new data
  assign line_a_q = fwd_r ? fwd_a_r : rd_a_r;
  assign line_b_q = fwd_r ? fwd_b_r : rd_b_r;

  always_ff @(posedge clk) begin
    if (a_fire) begin
      mem_a[a_addr_r] <= a_pix_r;
      mem_b[a_addr_r] <= line_a_q;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_a_r  <= mem_a[pos_c];
      rd_b_r  <= mem_b[pos_c];
      fwd_r   <= a_fire && (a_addr_r == pos_c);
      fwd_a_r <= a_pix_r;
      fwd_b_r <= line_a_q;
    end
  end

  // 3x3 window, row-major; shift left and drop the new column in on the right
  pix_t win_r   [3][3];
  pix_t win_nxt [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = win_r[i][1];
      win_nxt[i][1] = win_r[i][2];
    end
    win_nxt[0][2] = line_b_q;
    win_nxt[1][2] = line_a_q;
    win_nxt[2][2] = a_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (a_fire) begin
      win_r <= win_nxt;
    end
  end

  // Per-channel filter on the updated window
  tap9_t            tap_red, tap_green, tap_blue;
  logic [PIX_W-1:0] filt_red, filt_green, filt_blue;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        tap_red[i*3+j]   = win_nxt[i][j][3*PIX_W-1:2*PIX_W];
        tap_green[i*3+j] = win_nxt[i][j][2*PIX_W-1:PIX_W];
        tap_blue[i*3+j]  = win_nxt[i][j][PIX_W-1:0];
      end
    end
    filt_red   = filt_chan(kmode_r, tap_red);
    filt_green = filt_chan(kmode_r, tap_green);
    filt_blue  = filt_chan(kmode_r, tap_blue);
  end

  // Output register
  logic [PIX_W-1:0] out_red_r, out_green_r, out_blue_r;
  logic             out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= a_fire && a_res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire && a_res_r) begin
      if (a_border_r) begin
        // Border pixel: pass the window center through
        out_red_r   <= win_nxt[1][1][3*PIX_W-1:2*PIX_W];
        out_green_r <= win_nxt[1][1][2*PIX_W-1:PIX_W];
        out_blue_r  <= win_nxt[1][1][PIX_W-1:0];
      end else begin
        out_red_r   <= filt_red;
        out_green_r <= filt_green;
        out_blue_r  <= filt_blue;
      end
      out_last_r <= a_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = out_red_r;
  assign out_green      = out_green_r;
  assign out_blue       = out_blue_r;
  assign out_frame_last = out_last_r;

endmodule

@@ rtl/rgbk_chk.sv @@
module rgbk_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [rgbk_pkg::PIX_W-1:0]      in_red,
  input logic [rgbk_pkg::PIX_W-1:0]      in_green,
  input logic [rgbk_pkg::PIX_W-1:0]      in_blue,
  input logic                            in_is_pad,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [rgbk_pkg::PIX_W-1:0]      out_red,
  input logic [rgbk_pkg::PIX_W-1:0]      out_green,
  input logic [rgbk_pkg::PIX_W-1:0]      out_blue,
  input logic                            out_frame_last,
  input logic                            cfg_wr_en,
  input logic [rgbk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [rgbk_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rgbk_pkg::*;

  // Reset empties the result register
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid
      && $stable({out_red, out_green, out_blue, out_frame_last}))
    else $error("stalled result changed");

  // With room at the output, the input side never stalls
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with free output");

  // A new result comes from an earlier accepted input transaction
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching input transaction");

endmodule

bind rgb_3x3_kernel_convolution rgbk_chk u_rgbk_chk (.*);

@@ verif/rgb_conv_checker.sv @@
`timescale 1ns / 1ps

// Watches all three ports of the convolution block, predicts each result pixel
// and compares it with the result channel in order.
module rgb_conv_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [rgbk_pkg::PIX_W-1:0]      in_red,
  input  logic [rgbk_pkg::PIX_W-1:0]      in_green,
  input  logic [rgbk_pkg::PIX_W-1:0]      in_blue,
  input  logic                            in_is_pad,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [rgbk_pkg::PIX_W-1:0]      out_red,
  input  logic [rgbk_pkg::PIX_W-1:0]      out_green,
  input  logic [rgbk_pkg::PIX_W-1:0]      out_blue,
  input  logic                            out_frame_last,
  input  logic                            cfg_wr_en,
  input  logic [rgbk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgbk_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              errors,
  output int                              results_owed,
  output logic                            frame_start
);
  import rgbk_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_last;
  } conv_pixel_t;

  // Weights per kernel, row-major, top-left first.
  int kernel_taps [4][9] = '{
    '{-1, -1, -1, -1,  8, -1, -1, -1, -1},
    '{ 0, -1,  0, -1,  5, -1,  0, -1,  0},
    '{ 1,  1,  1,  1,  1,  1,  1,  1,  1},
    '{ 1,  2,  1,  2,  4,  2,  1,  2,  1}
  };

  kmode_t               kernel_sel;
  logic [CFG_DIM_W-1:0] width_reg;
  logic [CFG_DIM_W-1:0] height_reg;
  pix_t                 row_above [MAX_WIDTH_DEF];
  pix_t                 row_above2 [MAX_WIDTH_DEF];
  pix_t                 win [3][3];
  int unsigned          col_pos;
  int unsigned          row_pos;
  conv_pixel_t          expected_pixels [$];

  function automatic int unsigned clamp_dim(logic [CFG_DIM_W-1:0] v, int unsigned hi);
    if (v < DIM_MIN) begin
      return DIM_MIN;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] filter_channel(int lsb);
    int acc;
    int r;
    int c;
    acc = 0;
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 3; c++) begin
        acc += int'(win[r][c][lsb +: PIX_W]) * kernel_taps[kernel_sel][3 * r + c];
      end
    end
    if (kernel_sel == KM_BOX) begin
      acc = (acc + BOX_RND) / 9;
    end else if (kernel_sel == KM_GAUSS) begin
      acc = (acc + GAUSS_RND) / 16;
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > PIX_MAX) begin
      acc = PIX_MAX;
    end
    return acc[PIX_W-1:0];
  endfunction

  // Shift one pixel into the window and line stores; queue the pixel that leaves.
  task automatic take_pixel(input pix_t pix);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    int unsigned y;
    int unsigned x;
    logic        emits;
    conv_pixel_t res;
    w = clamp_dim(width_reg, MAX_WIDTH_DEF);
    h = clamp_dim(height_reg, MAX_HEIGHT_DEF);
    // restart a frame left out of range by a register change
    if (col_pos >= w || row_pos > h + 1) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = row_above2[c];
    win[1][2] = row_above[c];
    win[2][2] = pix;
    row_above2[c] = row_above[c];
    row_above[c] = pix;

    emits = 1'b0;
    y = 0;
    x = 0;
    if (c >= 1) begin
      if (r >= 1) begin
        y = r - 1;
        x = c - 1;
        emits = (y < h);
      end
    end else if (r >= 2) begin
      y = r - 2;
      x = w - 1;
      emits = (y < h);
    end

    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
    end

    if (emits) begin
      if (y == 0 || y == h - 1 || x == 0 || x == w - 1) begin
        res.red   = win[1][1][2*PIX_W +: PIX_W];
        res.green = win[1][1][PIX_W +: PIX_W];
        res.blue  = win[1][1][0 +: PIX_W];
      end else begin
        res.red   = filter_channel(2 * PIX_W);
        res.green = filter_channel(PIX_W);
        res.blue  = filter_channel(0);
      end
      res.frame_last = (y == h - 1 && x == w - 1);
      if (res.frame_last) begin
        col_pos = 0;
        row_pos = 0;
      end
      expected_pixels.push_back(res);
    end
  endtask

  always @(posedge clk) begin : track
    conv_pixel_t got;
    conv_pixel_t want;
    if (!rst_n) begin
      kernel_sel = KM_EDGE;
      width_reg  = CFG_DIM_W'(DIM_RESET);
      height_reg = CFG_DIM_W'(DIM_RESET);
      for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
        row_above[i]  = '0;
        row_above2[i] = '0;
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] = '0;
        end
      end
      col_pos = 0;
      row_pos = 0;
      errors  = 0;
      expected_pixels.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_KERNEL_MODE:  kernel_sel = kmode_t'(cfg_wdata[KMODE_W-1:0]);
          REG_IMAGE_WIDTH:  width_reg  = cfg_wdata[CFG_DIM_W-1:0];
          REG_IMAGE_HEIGHT: height_reg = cfg_wdata[CFG_DIM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        take_pixel(in_is_pad ? pix_t'('0) : {in_red, in_green, in_blue});
      end
      if (out_valid && out_ready) begin
        got = '{out_red, out_green, out_blue, out_frame_last};
        if (expected_pixels.size() == 0) begin
          $error("result with nothing pending: red %0d green %0d blue %0d frame_last %0d",
                 out_red, out_green, out_blue, out_frame_last);
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          if (got.red !== want.red) begin
            $error("out_red expected %0d actual %0d", want.red, got.red);
            errors++;
          end
          if (got.green !== want.green) begin
            $error("out_green expected %0d actual %0d", want.green, got.green);
            errors++;
          end
          if (got.blue !== want.blue) begin
            $error("out_blue expected %0d actual %0d", want.blue, got.blue);
            errors++;
          end
          if (got.frame_last !== want.frame_last) begin
            $error("out_frame_last expected %0d actual %0d", want.frame_last,
                   got.frame_last);
            errors++;
          end
        end
      end
    end
    results_owed = expected_pixels.size();
    frame_start  = (col_pos == 0 && row_pos == 0);
  end

endmodule

@@ verif/rgb_3x3_kernel_convolution_test.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the 3x3 RGB convolution block. The checker beside
// the block does all prediction and comparison; this module only feeds pixels,
// throttles both channels and writes the registers between phases.
module rgb_3x3_kernel_convolution_test;
  import rgbk_pkg::*;

  // Index past the last register: writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  // Cycles to let an in-flight pixel with no result leave the pipeline.
  localparam int SETTLE_CYCLES = 8;
  // Receiver hold-off, long enough to fill the block and stall its input.
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_PHASES = 16;
  localparam int PHASE_ITEMS = 75;

  localparam int STYLE_NOISE   = 0;
  localparam int STYLE_SMOOTH  = 1;
  localparam int STYLE_EXTREME = 2;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      in_red = '0;
  logic [PIX_W-1:0]      in_green = '0;
  logic [PIX_W-1:0]      in_blue = '0;
  logic                  in_is_pad = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      out_red;
  logic [PIX_W-1:0]      out_green;
  logic [PIX_W-1:0]      out_blue;
  logic                  out_frame_last;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int errors;
  int results_owed;
  logic frame_start;

  // Throttle knobs, in percent of cycles.
  int sender_idle_pct = 0;
  int stall_pct = 0;
  // Hold-off handshake between the stimulus and the receiver process.
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int items_sent = 0;
  logic [CFG_DIM_W-1:0] cur_width = CFG_DIM_W'(DIM_RESET);
  logic [CFG_DIM_W-1:0] cur_height = CFG_DIM_W'(DIM_RESET);

  rgb_3x3_kernel_convolution uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_is_pad      (in_is_pad),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_frame_last (out_frame_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  rgb_conv_checker conv_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_is_pad      (in_is_pad),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_frame_last (out_frame_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .errors         (errors),
    .results_owed   (results_owed),
    .frame_start    (frame_start)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: stall at random, or hold off for a whole stretch when asked.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic int unsigned eff_dim(logic [CFG_DIM_W-1:0] v, int unsigned hi);
    if (v < DIM_MIN) begin
      return DIM_MIN;
    end
    return (v > hi) ? hi : v;
  endfunction

  // Offer one transaction and hold it until the block takes it. Returns just
  // after the accepting edge, so the caller must offer again or rest at the
  // next falling edge.
  task automatic push_item(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                           input logic [PIX_W-1:0] b, input logic pad);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_red    <= r;
    in_green  <= g;
    in_blue   <= b;
    in_is_pad <= pad;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    items_sent++;
  endtask

  task automatic rest_sender();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Pause the sender until every pending result is out, then let a pixel
  // that causes no result clear the pipeline.
  task automatic wait_drained();
    rest_sender();
    while (results_owed != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Move to new settings at a safe point. Widening mid-frame would let
  // interior taps read line-store columns never written, so pad out to the
  // frame boundary first; narrowing mid-frame is left in on purpose.
  task automatic reconfigure(input kmode_t mode, input logic [CFG_DIM_W-1:0] w,
                             input logic [CFG_DIM_W-1:0] h);
    rest_sender();
    if (eff_dim(w, MAX_WIDTH_DEF) > eff_dim(cur_width, MAX_WIDTH_DEF)) begin
      while (!frame_start) begin
        push_item(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
        rest_sender();
      end
    end
    wait_drained();
    // Hold the write enable across all four writes; drop it once at the end.
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_KERNEL_MODE;
    cfg_wdata <= {(CFG_DATA_W-KMODE_W)'($urandom), mode};
    @(negedge clk);
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_wdata <= h;
    @(negedge clk);
    cfg_index <= REG_SPARE;
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_width  = w;
    cur_height = h;
  endtask

  // One frame plus its flush pads. Some kinds get flipped at random (a pad
  // inside the frame, a pixel among the pads); a broken frame stops early.
  task automatic send_frame(input int style, input bit broken, input int flip_pct);
    int unsigned w;
    int unsigned h;
    int unsigned total;
    int unsigned stop;
    logic [PIX_W-1:0] base_r;
    logic [PIX_W-1:0] base_g;
    logic [PIX_W-1:0] base_b;
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
    logic pad;
    w = eff_dim(cur_width, MAX_WIDTH_DEF);
    h = eff_dim(cur_height, MAX_HEIGHT_DEF);
    total = w * h + w + 1;
    stop = broken ? $urandom_range(total - 1, 1) : total;
    base_r = 8'($urandom_range(247, 8));
    base_g = 8'($urandom_range(247, 8));
    base_b = 8'($urandom_range(247, 8));
    for (int unsigned i = 0; i < stop; i++) begin
      pad = (i >= w * h);
      if ($urandom_range(99) < flip_pct) begin
        pad = !pad;
      end
      case (style)
        STYLE_SMOOTH: begin
          r = 8'(base_r + $urandom_range(16) - 8);
          g = 8'(base_g + $urandom_range(16) - 8);
          b = 8'(base_b + $urandom_range(16) - 8);
        end
        STYLE_EXTREME: begin
          r = $urandom_range(1) ? 8'hFF : 8'h00;
          g = $urandom_range(1) ? 8'hFF : 8'h00;
          b = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        default: begin
          r = 8'($urandom);
          g = 8'($urandom);
          b = 8'($urandom);
        end
      endcase
      push_item(r, g, b, pad);
    end
  endtask

  initial begin : stimulus
    int unsigned phase_start;
    int          frames;
    int          sel;
    logic [CFG_DIM_W-1:0] w;
    logic [CFG_DIM_W-1:0] h;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: smallest image, edge kernel. The center pixel drives red
    // below zero and green above 255; blue is flat and cancels to zero.
    reconfigure(KM_EDGE, CFG_DIM_W'(3), CFG_DIM_W'(3));
    for (int i = 0; i < 9; i++) begin
      push_item((i == 4) ? 8'h00 : 8'hFF, (i == 4) ? 8'hFF : 8'h00, 8'd128, 1'b0);
    end
    // Flush pads carry junk in their pixel fields; the last flush slot is a
    // real pixel instead of a pad.
    repeat (3) push_item(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
    push_item(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);

    // Directed: Gaussian on a flat-white red channel, a green center value
    // that lands exactly on a rounding half, and a pad inside the frame that
    // must act as a black pixel.
    reconfigure(KM_GAUSS, CFG_DIM_W'(3), CFG_DIM_W'(3));
    for (int i = 0; i < 9; i++) begin
      push_item(8'hFF, (i == 4) ? 8'd2 : 8'd0, 8'($urandom), (i == 3));
    end
    repeat (4) push_item(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);

    // Random phases: mostly small images with well-formed frames, some
    // broken frames and misplaced pads. Widths and heights occasionally
    // fall outside 3..MAX and get clamped by the block.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      sel = $urandom_range(7);
      w = (sel == 0) ? CFG_DIM_W'($urandom_range(2)) :
          (sel == 1) ? CFG_DIM_W'($urandom_range(40, 13)) :
                       CFG_DIM_W'($urandom_range(12, 3));
      sel = $urandom_range(7);
      h = (sel == 0) ? CFG_DIM_W'($urandom_range(2)) :
          (sel == 1) ? CFG_DIM_W'($urandom_range(20, 9)) :
                       CFG_DIM_W'($urandom_range(8, 3));
      reconfigure(kmode_t'((p + p / 4) % 4), w, h);

      case (p % 4)
        0: begin
          sender_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 87;
          stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          stall_pct = 87;
        end
        default: begin
          sender_idle_pct = 32;
          stall_pct = 32;
        end
      endcase

      phase_start = items_sent;
      frames = 0;
      // The first two phases always reach their second frame, where the
      // pressure cases below kick in.
      while (items_sent - phase_start < PHASE_ITEMS || (p < 2 && frames < 2)) begin
        // Back-pressure: the receiver holds off while the sender keeps
        // offering at full rate, so the block fills and stalls its input.
        if (p == 0 && frames == 1) begin
          hold_req++;
        end
        // Pause the sender until every pending result has come out.
        if (p == 1 && frames == 1) begin
          wait_drained();
        end
        send_frame($urandom_range(STYLE_EXTREME), ($urandom_range(99) < 10), 2);
        frames++;
      end
    end

    // Drain everything, then give a stray result time to show up.
    rest_sender();
    stall_pct = 0;
    while (results_owed != 0) begin
      @(negedge clk);
    end
    repeat (4 * SETTLE_CYCLES) @(negedge clk);

    if (errors == 0 && results_owed == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule

@@ rgb_3x3_kernel_convolution.f @@
rtl/rgbk_pkg.sv
rtl/rgb_3x3_kernel_convolution.sv
rtl/rgbk_chk.sv
verif/rgb_conv_checker.sv
verif/rgb_3x3_kernel_convolution_test.sv
